FILE: hdl/okvt_pkg.sv
// shared types and constants for the object-keyed value table
// no dependencies
`timescale 1ns / 1ps

package okvt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_GET = 2'd1,
    CMD_HAS = 2'd2,
    CMD_DEL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_NOT_OBJECT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ACT,
    S_RESP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             scan_rd;
    logic [IDX_W-1:0] scan_addr;
    logic             act;
  } ctrl_cmd_t;

endpackage

FILE: hdl/okvt_ctrl.sv
// request sequencer for the object-keyed value table
// depends on okvt_pkg
`timescale 1ns / 1ps

module okvt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               key_is_object,
  output logic               busy,
  output logic               out_valid,
  output okvt_pkg::ctrl_cmd_t cmd
);
  import okvt_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    cmd.load      = 1'b0;
    cmd.scan_rd   = 1'b0;
    cmd.scan_addr = scan_idx_r;
    cmd.act       = 1'b0;
    busy          = (state_r != S_IDLE);
    out_valid     = 1'b0;
    case (state_r)
      S_IDLE: begin
        scan_idx_nxt = '0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = key_is_object ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      // last slot compare lands here
      S_DRAIN: state_nxt = S_ACT;
      S_ACT: begin
        cmd.act   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/okvt_dp.sv
// slot memories, key compare and result registers of the value table
// depends on okvt_pkg
`timescale 1ns / 1ps

module okvt_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  okvt_pkg::ctrl_cmd_t        cmd,
  input  logic [1:0]                 in_command,
  input  logic                       in_key_is_object,
  input  logic [okvt_pkg::KEY_W-1:0] in_key_id,
  input  logic [okvt_pkg::VAL_W-1:0] in_new_value,
  output logic                       out_hit,
  output logic [okvt_pkg::VAL_W-1:0] out_read_value,
  output logic [1:0]                 out_status
);
  import okvt_pkg::*;

  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [VAL_W-1:0] val_mem [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;

  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  logic             hit_r, hit_nxt;
  logic             get_hit_r, get_hit_nxt;
  status_t          status_r, status_nxt;

  logic             wr_key_en;
  logic             wr_val_en;
  logic [IDX_W-1:0] wr_idx;
  logic             val_rd_en;

  // memories, registered read
  always_ff @(posedge clk) begin
    if (wr_key_en) key_mem[wr_idx] <= key_r;
    if (cmd.scan_rd) key_rd_r <= key_mem[cmd.scan_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_val_en) val_mem[wr_idx] <= value_r;
    if (val_rd_en) val_rd_r <= val_mem[match_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      cmp_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmd.scan_addr;
    found_r     <= found_nxt;
    match_idx_r <= match_idx_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    hit_r       <= hit_nxt;
    get_hit_r   <= get_hit_nxt;
    status_r    <= status_nxt;
    if (cmd.load) begin
      cmd_r   <= cmd_t'(in_command);
      key_r   <= in_key_id;
      value_r <= in_new_value;
    end
  end

  // scan compare: first matching slot and lowest free slot
  always_comb begin
    found_nxt     = found_r;
    match_idx_nxt = match_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    if (cmd.load) begin
      found_nxt = 1'b0;
      free_nxt  = 1'b0;
    end else if (cmp_vld_r) begin
      if (valid_r[cmp_idx_r] && key_rd_r == key_r && !found_r) begin
        found_nxt     = 1'b1;
        match_idx_nxt = cmp_idx_r;
      end
      if (!valid_r[cmp_idx_r] && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end
  end

  // table update and result
  always_comb begin
    valid_nxt   = valid_r;
    hit_nxt     = hit_r;
    get_hit_nxt = get_hit_r;
    status_nxt  = status_r;
    wr_key_en   = 1'b0;
    wr_val_en   = 1'b0;
    wr_idx      = match_idx_r;
    val_rd_en   = 1'b0;
    if (cmd.load) begin
      hit_nxt     = 1'b0;
      get_hit_nxt = 1'b0;
      status_nxt  = in_key_is_object ? STAT_OK : STAT_NOT_OBJECT;
    end else if (cmd.act) begin
      hit_nxt = found_r;
      case (cmd_r)
        CMD_SET: begin
          if (found_r) begin
            wr_val_en = 1'b1;
          end else if (free_r) begin
            wr_idx             = free_idx_r;
            wr_key_en          = 1'b1;
            wr_val_en          = 1'b1;
            valid_nxt[free_idx_r] = 1'b1;
          end else begin
            status_nxt = STAT_FULL;
          end
        end
        CMD_GET: begin
          val_rd_en   = found_r;
          get_hit_nxt = found_r;
        end
        CMD_HAS: ;
        CMD_DEL: begin
          if (found_r) valid_nxt[match_idx_r] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_hit        = hit_r;
  assign out_read_value = get_hit_r ? val_rd_r : '0;
  assign out_status     = status_r;

endmodule

FILE: hdl/object_keyed_value_table.sv
// top level of the object-keyed value table
// depends on okvt_pkg, okvt_ctrl and okvt_dp
`timescale 1ns / 1ps

// keyed table of TABLE_ENTRIES slots mapping a 64-bit object identity to a
// 64-bit value word. a request is taken when start is high and busy is low;
// every request yields exactly one result, shown for a single cycle with
// out_valid high. the receiver cannot stall, so it must take the result in
// that cycle. for a request with an object key the key memory is scanned
// one slot per cycle through its single read port, then a drain state lets
// the last compare land, an act state updates the table or reads the value
// memory, and a result state presents the result. a request whose key is
// not an object skips the scan and goes from accept straight to the result
// state. valid marks are flops cleared by reset, so the table is usable
// right after reset with no clearing pass

module object_keyed_value_table (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_command,
  input  logic                       in_key_is_object,
  input  logic [okvt_pkg::KEY_W-1:0] in_key_id,
  input  logic [okvt_pkg::VAL_W-1:0] in_new_value,
  // result channel, one cycle strobe
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [okvt_pkg::VAL_W-1:0] out_read_value,
  output logic [1:0]                 out_status
);
  import okvt_pkg::*;

  ctrl_cmd_t cmd;

  // sequencer: accept, slot scan, update, result strobe
  okvt_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .key_is_object (in_key_is_object),
    .busy          (busy),
    .out_valid     (out_valid),
    .cmd           (cmd)
  );

  // slot memories, valid marks, key compare and result registers
  okvt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_command       (in_command),
    .in_key_is_object (in_key_is_object),
    .in_key_id        (in_key_id),
    .in_new_value     (in_new_value),
    .out_hit          (out_hit),
    .out_read_value   (out_read_value),
    .out_status       (out_status)
  );

endmodule

FILE: tb/sv/okvt_table_checker.sv
`timescale 1ns / 1ps
// reply checker for the object-keyed value table: keeps a shadow table,
// predicts the reply of every accepted request and compares it field by field
// depends on okvt_pkg

module okvt_table_checker
  import okvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_command,
  input  logic             in_key_is_object,
  input  logic [KEY_W-1:0] in_key_id,
  input  logic [VAL_W-1:0] in_new_value,
  input  logic             out_valid,
  input  logic             out_hit,
  input  logic [VAL_W-1:0] out_read_value,
  input  logic [1:0]       out_status,
  output int               fail_count,
  output int               pending,
  output int               reply_count,
  output int               hit_count,
  output int               full_count,
  output int               reject_count
);

  typedef struct {
    logic             hit;
    logic [VAL_W-1:0] value;
    status_t          status;
  } table_reply_t;

  logic [KEY_W-1:0] shadow_key  [TABLE_ENTRIES];
  logic [VAL_W-1:0] shadow_val  [TABLE_ENTRIES];
  logic             shadow_used [TABLE_ENTRIES];
  table_reply_t     expected_replies [$];

  // applies one request to the shadow table and returns its reply
  function automatic table_reply_t apply_request(cmd_t cmd, logic is_obj,
                                                 logic [KEY_W-1:0] key,
                                                 logic [VAL_W-1:0] val);
    table_reply_t r;
    int found;
    int free_slot;
    r.hit = 1'b0;
    r.value = '0;
    r.status = STAT_OK;
    found = -1;
    free_slot = -1;
    if (!is_obj) begin
      r.status = STAT_NOT_OBJECT;
      return r;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (shadow_used[i] && shadow_key[i] == key && found < 0) found = i;
      if (!shadow_used[i] && free_slot < 0) free_slot = i;
    end
    case (cmd)
      CMD_SET: begin
        if (found >= 0) begin
          shadow_val[found] = val;
          r.hit = 1'b1;
        end else if (free_slot < 0) begin
          r.status = STAT_FULL;
        end else begin
          shadow_key[free_slot] = key;
          shadow_val[free_slot] = val;
          shadow_used[free_slot] = 1'b1;
        end
      end
      CMD_GET: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.value = shadow_val[found];
        end
      end
      CMD_HAS: begin
        r.hit = (found >= 0);
      end
      default: begin
        if (found >= 0) begin
          shadow_used[found] = 1'b0;
          r.hit = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    table_reply_t pred;
    int errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) shadow_used[i] = 1'b0;
      expected_replies.delete();
      fail_count <= 0;
      pending <= 0;
      reply_count <= 0;
      hit_count <= 0;
      full_count <= 0;
      reject_count <= 0;
    end else begin
      // compare before predicting: a reply never belongs to a request
      // accepted at the same edge
      if (out_valid) begin
        reply_count <= reply_count + 1;
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with nothing expected, hit %0b value %h status %0d",
                   $time, out_hit, out_read_value, out_status);
          errs++;
        end else begin
          want = expected_replies.pop_front();
          if (out_hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, actual %0b",
                     $time, want.hit, out_hit);
            errs++;
          end
          if (out_read_value !== want.value) begin
            $display("%0t: read_value mismatch, expected %h, actual %h",
                     $time, want.value, out_read_value);
            errs++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        pred = apply_request(cmd_t'(in_command), in_key_is_object, in_key_id,
                             in_new_value);
        expected_replies.insert(expected_replies.size(), pred);
        if (pred.hit) hit_count <= hit_count + 1;
        if (pred.status == STAT_FULL) full_count <= full_count + 1;
        if (pred.status == STAT_NOT_OBJECT) reject_count <= reject_count + 1;
      end
      fail_count <= fail_count + errs;
      pending <= expected_replies.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// top of the object-keyed value table bench: clock, reset, request stimulus
// and verdict; depends on okvt_pkg, object_keyed_value_table, okvt_table_checker

module tb_top;
  import okvt_pkg::*;

  localparam int RANDOM_REQUESTS = 1000;
  // pool a little larger than the table so sets run into a full table
  localparam int KEY_POOL = 24;
  // well above the slowest run of about 1030 requests, each with the longest
  // busy time and idle gap, so this leaves ample margin
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_EVERY = 250;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_command;
  logic             in_key_is_object;
  logic [KEY_W-1:0] in_key_id;
  logic [VAL_W-1:0] in_new_value;
  logic             out_valid;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;
  logic [1:0]       out_status;

  int fail_count;
  int pending;
  int reply_count;
  int hit_count;
  int full_count;
  int reject_count;
  int cycle_count = 0;
  int request_count = 0;

  logic [KEY_W-1:0] key_pool [KEY_POOL];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  object_keyed_value_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_key_is_object (in_key_is_object),
    .in_key_id        (in_key_id),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_read_value   (out_read_value),
    .out_status       (out_status)
  );

  okvt_table_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_key_is_object (in_key_is_object),
    .in_key_id        (in_key_id),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending          (pending),
    .reply_count      (reply_count),
    .hit_count        (hit_count),
    .full_count       (full_count),
    .reject_count     (reject_count)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // drive one request from a falling edge and hold it until the block takes
  // it; returns on the falling edge after the accept with start still high,
  // so a following request keeps start up without a drop
  task automatic issue(cmd_t cmd, logic is_obj, logic [KEY_W-1:0] key,
                       logic [VAL_W-1:0] val);
    in_command = cmd;
    in_key_is_object = is_obj;
    in_key_id = key;
    in_new_value = val;
    start = 1'b1;
    do @(posedge clk); while (busy);
    request_count++;
    @(negedge clk);
  endtask

  // sender idle for a number of cycles
  task automatic idle(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // sender holds off until every outstanding reply has come back
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed requests on pooled keys; a few fresh keys and
  // non-object keys as noise
  task automatic issue_random();
    int pick;
    cmd_t cmd;
    logic is_obj;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 35) cmd = CMD_SET;
    else if (pick < 60) cmd = CMD_GET;
    else if (pick < 80) cmd = CMD_HAS;
    else cmd = CMD_DEL;
    is_obj = ($urandom_range(0, 99) >= 4);
    if ($urandom_range(0, 99) < 8) key = rand64();
    else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    issue(cmd, is_obj, key, rand64());
  endtask

  initial begin
    int burst;
    int next_drain;
    int total;
    start = 1'b0;
    in_command = CMD_SET;
    in_key_is_object = 1'b0;
    in_key_id = '0;
    in_new_value = '0;
    rst_n = 1'b0;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = rand64();
    // extreme keys live in the pool too
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: basic life of one entry on the all-zero key
    issue(CMD_SET, 1'b1, '0, '1);
    issue(CMD_GET, 1'b1, '0, '0);
    issue(CMD_HAS, 1'b1, '0, '0);
    issue(CMD_SET, 1'b1, '0, '0);        // update in place, reports a hit
    issue(CMD_DEL, 1'b1, '0, '1);
    issue(CMD_GET, 1'b1, '0, '1);        // miss after delete reads zero
    // non-object key rejected for every command, table untouched
    issue(CMD_SET, 1'b0, '1, '1);
    issue(CMD_GET, 1'b0, '1, '1);
    issue(CMD_HAS, 1'b0, '1, '1);
    issue(CMD_DEL, 1'b0, '1, '1);
    // fill every slot, then one more new key is refused as table full
    for (int i = 0; i < TABLE_ENTRIES; i++) issue(CMD_SET, 1'b1, key_pool[i], rand64());
    issue(CMD_SET, 1'b1, key_pool[TABLE_ENTRIES], '1);
    drain();

    // random part: bursts of random length, random gaps, some with no gap
    total = request_count + RANDOM_REQUESTS;
    next_drain = request_count + DRAIN_EVERY;
    while (request_count < total) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && request_count < total; b++) issue_random();
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 30));
      if (request_count >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
    end

    // wait for the last replies, then watch a while for stray strobes
    drain();
    repeat (40) @(posedge clk);

    $display("ran %0d requests, %0d replies checked", request_count, reply_count);
    $display("predicted %0d hits, %0d table-full sets, %0d non-object rejects",
             hit_count, full_count, reject_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d replies missing", fail_count, pending);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
